// ===== rtl/core/cs2u16_pkg.sv =====
// Shared types and constants for the charset to UTF-16 decoder.
// Depends on nothing; every other file of the decoder imports it.
package cs2u16_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] MODE_UTF8    = 3'd0;
  localparam logic [2:0] MODE_LATIN1  = 3'd1;
  localparam logic [2:0] MODE_ASCII   = 3'd2;
  localparam logic [2:0] MODE_U16BE   = 3'd3;
  localparam logic [2:0] MODE_U16LE   = 3'd4;
  localparam logic [2:0] MODE_U16BOM  = 3'd5;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        last_unit;
  } unit_word_t;

  // A decoded byte: some replacement units, then up to two real units.
  typedef struct packed {
    logic [2:0]  reps;
    logic [1:0]  units;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        last;
  } cmd_t;

endpackage

// ===== rtl/core/charset_to_utf16_decoder.sv =====
// Top level of the charset to UTF-16 decoder.
// Instantiates cs2u16_front, cs2u16_queue and cs2u16_back; uses cs2u16_pkg.
//
//   channel     signals                          direction  moves
//   byte        byte_valid byte_ready byte_data  in         one raw byte word
//   unit        unit_valid unit_ready unit_data  out        one UTF-16 unit word
//   cfg         cfg_wr_en cfg_wr_data            in         charset mode write
//
// A byte word is accepted in every cycle while the command queue has room.
// The back end sends one unit word per cycle while unit_ready is high, so a byte
// that yields k words holds it until all k are sent; the queue of QUEUE_DEPTH commands absorbs bursts.
// An accepted byte's command is written into the queue, and its unit words leave through the registered output stage.
// Reset and every mode write return the stream state to its start.
// A stall on the unit side fills the queue and then drops byte_ready.
module charset_to_utf16_decoder #(
  parameter int QUEUE_DEPTH = cs2u16_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_wr_data,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  cs2u16_pkg::byte_word_t byte_data,
  output logic                   unit_valid,
  input  logic                   unit_ready,
  output cs2u16_pkg::unit_word_t unit_data
);
  import cs2u16_pkg::*;

  cmd_t cmd, head;
  logic cmd_push, take, pop, empty, full;

  assign byte_ready = !full;
  assign take       = byte_valid && byte_ready;

  cs2u16_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (byte_data),
    .take        (take),
    .cmd         (cmd),
    .cmd_push    (cmd_push)
  );

  cs2u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  cs2u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (unit_valid),
    .out_ready (unit_ready),
    .out_word  (unit_data)
  );

endmodule

// ===== rtl/core/cs2u16_front.sv =====
// Front end of the decoder: holds the charset register and stream state,
// and turns each accepted byte that yields units or ends a string into one queue command. Depends on cs2u16_pkg.
module cs2u16_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  cs2u16_pkg::byte_word_t in_word,
  input  logic               take,
  output cs2u16_pkg::cmd_t   cmd,
  output logic               cmd_push
);
  import cs2u16_pkg::*;

  logic [2:0]  mode;
  logic [20:0] acc, acc_next, cp_off;
  logic [2:0]  seq_len, seq_len_next;
  logic [2:0]  gathered, gathered_next;
  logic [7:0]  held, held_next;
  logic        held_valid, held_valid_next;
  logic        at_start, at_start_next;
  logic        le, le_next;
  logic [20:0] least;
  logic [7:0]  b;
  logic        last;
  logic        bom;
  logic [2:0]  reps;
  logic [1:0]  units;
  logic [15:0] u0, u1;

  always_comb begin
    b               = in_word.data_byte;
    last            = in_word.last_byte;
    acc_next        = acc;
    seq_len_next    = seq_len;
    gathered_next   = gathered;
    held_next       = held;
    held_valid_next = held_valid;
    at_start_next   = at_start;
    le_next         = le;
    least           = 21'h80;
    cp_off          = '0;
    bom             = 1'b0;
    reps            = '0;
    units           = '0;
    u0              = '0;
    u1              = '0;
    case (mode)
      MODE_UTF8: begin
        if (seq_len != 3'd0 && b[7:6] == 2'b10) begin
          acc_next      = {acc[14:0], b[5:0]};
          gathered_next = gathered + 3'd1;
          if (gathered_next >= seq_len) begin
            if (seq_len == 3'd2) begin
              least = 21'h80;
            end else if (seq_len == 3'd3) begin
              least = 21'h800;
            end else begin
              least = 21'h10000;
            end
            if (acc_next < least || acc_next > 21'h10FFFF ||
                (acc_next >= 21'hD800 && acc_next <= 21'hDFFF)) begin
              reps = gathered_next;
            end else if (acc_next <= 21'hFFFF) begin
              units = 2'd1;
              u0    = acc_next[15:0];
            end else begin
              cp_off = acc_next - 21'h10000;
              units  = 2'd2;
              u0     = {6'b110110, cp_off[19:10]};
              u1     = {6'b110111, cp_off[9:0]};
            end
            seq_len_next  = '0;
            gathered_next = '0;
            acc_next      = '0;
          end
        end else begin
          if (seq_len != 3'd0) begin
            reps = gathered;
          end
          seq_len_next  = '0;
          gathered_next = '0;
          acc_next      = '0;
          if (b[7] == 1'b0) begin
            units = 2'd1;
            u0    = {8'h00, b};
          end else if (b[7:5] == 3'b110) begin
            acc_next      = {16'h0, b[4:0]};
            seq_len_next  = 3'd2;
            gathered_next = 3'd1;
          end else if (b[7:4] == 4'b1110) begin
            acc_next      = {17'h0, b[3:0]};
            seq_len_next  = 3'd3;
            gathered_next = 3'd1;
          end else if (b[7:3] == 5'b11110) begin
            acc_next      = {18'h0, b[2:0]};
            seq_len_next  = 3'd4;
            gathered_next = 3'd1;
          end else begin
            units = 2'd1;
            u0    = REPLACEMENT;
          end
        end
        if (last && seq_len_next != 3'd0) begin
          reps = reps + gathered_next;
        end
      end
      MODE_ASCII: begin
        units = 2'd1;
        u0    = b[7] ? REPLACEMENT : {8'h00, b};
      end
      MODE_U16BE, MODE_U16LE, MODE_U16BOM: begin
        if (!held_valid) begin
          held_next       = b;
          held_valid_next = 1'b1;
          if (last) begin
            units = 2'd1;
            u0    = REPLACEMENT;
          end
        end else begin
          held_next       = '0;
          held_valid_next = 1'b0;
          at_start_next   = 1'b0;
          if (mode == MODE_U16BOM && at_start) begin
            if (held == 8'hFE && b == 8'hFF) begin
              le_next = 1'b0;
              bom     = 1'b1;
            end else if (held == 8'hFF && b == 8'hFE) begin
              le_next = 1'b1;
              bom     = 1'b1;
            end
          end
          if (!bom) begin
            units = 2'd1;
            if (mode == MODE_U16LE || (mode == MODE_U16BOM && le)) begin
              u0 = {b, held};
            end else begin
              u0 = {held, b};
            end
          end
        end
      end
      default: begin
        units = 2'd1;
        u0    = {8'h00, b};
      end
    endcase
    if (last) begin
      acc_next        = '0;
      seq_len_next    = '0;
      gathered_next   = '0;
      held_next       = '0;
      held_valid_next = 1'b0;
      at_start_next   = 1'b1;
      le_next         = 1'b0;
    end
    cmd.reps  = reps;
    cmd.units = units;
    cmd.unit0 = u0;
    cmd.unit1 = u1;
    cmd.last  = last;
    cmd_push  = take && (reps != 3'd0 || units != 2'd0 || last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_LATIN1;
      acc        <= '0;
      seq_len    <= '0;
      gathered   <= '0;
      held       <= '0;
      held_valid <= 1'b0;
      at_start   <= 1'b1;
      le         <= 1'b0;
    end else if (cfg_wr_en) begin
      mode       <= cfg_wr_data;
      acc        <= '0;
      seq_len    <= '0;
      gathered   <= '0;
      held       <= '0;
      held_valid <= 1'b0;
      at_start   <= 1'b1;
      le         <= 1'b0;
    end else if (take) begin
      acc        <= acc_next;
      seq_len    <= seq_len_next;
      gathered   <= gathered_next;
      held       <= held_next;
      held_valid <= held_valid_next;
      at_start   <= at_start_next;
      le         <= le_next;
    end
  end

endmodule

// ===== rtl/core/cs2u16_queue.sv =====
// Command queue between the front and back ends of the decoder.
// Depends on cs2u16_pkg for the command type.
module cs2u16_queue #(
  parameter int DEPTH = cs2u16_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cs2u16_pkg::cmd_t push_cmd,
  input  logic             pop,
  output cs2u16_pkg::cmd_t head,
  output logic             empty,
  output logic             full
);
  import cs2u16_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/cs2u16_back.sv =====
// Back end of the decoder: expands each queued command into output words,
// one per cycle while out_ready is high, through a registered output stage. Depends on cs2u16_pkg.
module cs2u16_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cs2u16_pkg::cmd_t       head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cs2u16_pkg::unit_word_t out_word
);
  import cs2u16_pkg::*;

  logic [1:0] pos;
  logic [2:0] total, last_pos, idx;
  logic       load, at_end;
  unit_word_t elem;

  always_comb begin
    load     = !out_valid || out_ready;
    total    = head.reps + {1'b0, head.units};
    last_pos = (total == 3'd0) ? 3'd0 : total - 3'd1;
    at_end   = ({1'b0, pos} == last_pos);
    idx      = {1'b0, pos} - head.reps;
    if (total == 3'd0) begin
      elem.code_unit = '0;
      elem.has_unit  = 1'b0;
    end else if ({1'b0, pos} < head.reps) begin
      elem.code_unit = REPLACEMENT;
      elem.has_unit  = 1'b1;
    end else begin
      elem.code_unit = idx[0] ? head.unit1 : head.unit0;
      elem.has_unit  = 1'b1;
    end
    elem.last_unit = head.last && at_end;
    pop            = load && !empty && at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        pos <= at_end ? 2'd0 : pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_word <= elem;
    end
  end

endmodule

// ===== tb/sv/utf16_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the charset to UTF-16 decoder: predicts the unit words of every accepted
// byte word and compares them, in order, with the unit words the block sends.
// Depends on cs2u16_pkg.
module utf16_unit_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_wr_data,
  input  logic                   byte_valid,
  input  logic                   byte_ready,
  input  cs2u16_pkg::byte_word_t byte_data,
  input  logic                   unit_valid,
  input  logic                   unit_ready,
  input  cs2u16_pkg::unit_word_t unit_data,
  output int                     errors,
  output int                     pending
);
  import cs2u16_pkg::*;

  logic [2:0]  mode;
  logic [20:0] cp_acc;
  int          seq_len;
  int          held_count;
  logic [7:0]  odd_byte;
  bit          odd_valid;
  bit          bom_open;
  bit          little_end;
  unit_word_t  units[4];
  int          n_units;
  unit_word_t  units_due[$];
  unit_word_t  want;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, exp_val);
    errors++;
  endtask

  function automatic void restart_stream();
    cp_acc = '0;
    seq_len = 0;
    held_count = 0;
    odd_byte = '0;
    odd_valid = 1'b0;
    bom_open = 1'b1;
    little_end = 1'b0;
  endfunction

  function automatic void add_unit(input logic [15:0] u);
    if (n_units < 4) begin
      units[n_units] = '{code_unit: u, has_unit: 1'b1, last_unit: 1'b0};
      n_units++;
    end
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < held_count; k++) add_unit(REPLACEMENT);
    seq_len = 0;
    held_count = 0;
    cp_acc = '0;
  endfunction

  function automatic void close_sequence();
    logic [20:0] floor_cp;
    logic [20:0] offset;
    floor_cp = (seq_len == 2) ? 21'h80 : (seq_len == 3) ? 21'h800 : 21'h10000;
    if (cp_acc < floor_cp || cp_acc > 21'h10FFFF ||
        (cp_acc >= 21'hD800 && cp_acc <= 21'hDFFF)) begin
      flush_held();
    end else begin
      if (cp_acc <= 21'hFFFF) begin
        add_unit(cp_acc[15:0]);
      end else begin
        offset = cp_acc - 21'h10000;
        add_unit({6'b110110, offset[19:10]});
        add_unit({6'b110111, offset[9:0]});
      end
      seq_len = 0;
      held_count = 0;
      cp_acc = '0;
    end
  endfunction

  function automatic void utf8_byte(input logic [7:0] b);
    if (seq_len != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        held_count++;
        if (held_count >= seq_len) close_sequence();
        return;
      end
      // A byte that breaks the sequence is decoded again as a new lead.
      flush_held();
    end
    if (!b[7]) begin
      add_unit({8'h00, b});
    end else if (b[7:5] == 3'b110) begin
      cp_acc = {16'h0000, b[4:0]};
      seq_len = 2;
      held_count = 1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = {17'h00000, b[3:0]};
      seq_len = 3;
      held_count = 1;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = {18'h00000, b[2:0]};
      seq_len = 4;
      held_count = 1;
    end else begin
      add_unit(REPLACEMENT);
    end
  endfunction

  function automatic void utf16_byte(input logic [7:0] b);
    logic [7:0] first;
    bit         lsb_first;
    if (!odd_valid) begin
      odd_byte = b;
      odd_valid = 1'b1;
      return;
    end
    first = odd_byte;
    odd_byte = '0;
    odd_valid = 1'b0;
    if (mode == MODE_U16BOM && bom_open) begin
      bom_open = 1'b0;
      if (first == 8'hFE && b == 8'hFF) begin
        little_end = 1'b0;
        return;
      end
      if (first == 8'hFF && b == 8'hFE) begin
        little_end = 1'b1;
        return;
      end
    end
    bom_open = 1'b0;
    lsb_first = (mode == MODE_U16LE) || (mode == MODE_U16BOM && little_end);
    add_unit(lsb_first ? {b, first} : {first, b});
  endfunction

  function automatic void decode_byte(input byte_word_t w);
    n_units = 0;
    case (mode)
      MODE_UTF8: begin
        utf8_byte(w.data_byte);
        if (w.last_byte && seq_len != 0) flush_held();
      end
      MODE_ASCII: begin
        add_unit(w.data_byte[7] ? REPLACEMENT : {8'h00, w.data_byte});
      end
      MODE_U16BE, MODE_U16LE, MODE_U16BOM: begin
        utf16_byte(w.data_byte);
        if (w.last_byte && odd_valid) add_unit(REPLACEMENT);
      end
      default: begin
        add_unit({8'h00, w.data_byte});
      end
    endcase
    if (w.last_byte) begin
      if (n_units == 0) begin
        units[0] = '{code_unit: 16'h0000, has_unit: 1'b0, last_unit: 1'b1};
        n_units = 1;
      end else begin
        units[n_units - 1].last_unit = 1'b1;
      end
      restart_stream();
    end
    for (int k = 0; k < n_units; k++) units_due.insert(units_due.size(), units[k]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_LATIN1;
      restart_stream();
      units_due.delete();
      errors = 0;
    end else begin
      if (unit_valid && unit_ready) begin
        if (units_due.size() == 0) begin
          report_mismatch("unexpected unit word, code_unit", unit_data.code_unit, 16'h0000);
        end else begin
          want = units_due.pop_front();
          if (unit_data.code_unit != want.code_unit) begin
            report_mismatch("code_unit", unit_data.code_unit, want.code_unit);
          end
          if (unit_data.has_unit != want.has_unit) begin
            report_mismatch("has_unit", {15'h0, unit_data.has_unit}, {15'h0, want.has_unit});
          end
          if (unit_data.last_unit != want.last_unit) begin
            report_mismatch("last_unit", {15'h0, unit_data.last_unit},
                            {15'h0, want.last_unit});
          end
        end
      end
      if (cfg_wr_en) begin
        mode = cfg_wr_data;
        restart_stream();
      end
      if (byte_valid && byte_ready) decode_byte(byte_data);
    end
    pending = units_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the charset to UTF-16 decoder: clock, reset, byte strings in every
// charset mode with random stalls on both channels, and the final verdict.
// Depends on cs2u16_pkg, charset_to_utf16_decoder and utf16_unit_checker.
module tb;
  import cs2u16_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int RANDOM_BYTES = 140;
  localparam int CALM_BYTES = 30;
  localparam int QUIET_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_word_t byte_data = '0;
  logic       unit_valid;
  logic       unit_ready = 1'b0;
  unit_word_t unit_data;
  int         errors;
  int         pending;
  bit         calm = 1'b0;
  int         sent = 0;
  int         quiet = 0;
  logic [7:0] text[$];

  always #10 clk = ~clk;

  charset_to_utf16_decoder uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_data   (byte_data),
    .unit_valid  (unit_valid),
    .unit_ready  (unit_ready),
    .unit_data   (unit_data)
  );

  utf16_unit_checker unit_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_data   (byte_data),
    .unit_valid  (unit_valid),
    .unit_ready  (unit_ready),
    .unit_data   (unit_data),
    .errors      (errors),
    .pending     (pending)
  );

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (unit_valid && unit_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        unit_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      unit_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text();
    for (int k = 0; k < text.size(); k++) send_byte(text[k], k == text.size() - 1);
    text.delete();
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void put_byte(input logic [7:0] v);
    text.insert(text.size(), v);
  endfunction

  function automatic logic [20:0] random_char_value(input int min_class);
    logic [20:0] v;
    case ($urandom_range(min_class, 3))
      0: begin
        v = 21'($urandom_range(0, 'h7F));
      end
      1: begin
        v = 21'($urandom_range('h80, 'h7FF));
      end
      2: begin
        v = 21'($urandom_range('h800, 'hF7FF));
        if (v >= 21'hD800) v = v + 21'h800;
      end
      default: begin
        v = 21'($urandom_range('h10000, 'h10FFFF));
      end
    endcase
    return v;
  endfunction

  function automatic void put_utf8_char(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Mostly well-formed characters; the rest are noise, cut-off sequences,
  // surrogates, overlong forms and values past the top of the code space.
  function automatic void put_utf8_element();
    case ($urandom_range(0, 9))
      0: begin
        put_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        put_utf8_char(random_char_value(1));
        void'(text.pop_back());
      end
      2: begin
        put_byte(8'hED);
        put_byte(8'($urandom_range('hA0, 'hBF)));
        put_byte(8'($urandom_range('h80, 'hBF)));
      end
      3: begin
        put_byte(8'($urandom_range('hC0, 'hC1)));
        put_byte(8'($urandom_range('h80, 'hBF)));
      end
      4: begin
        put_byte(8'($urandom_range('hF4, 'hF7)));
        put_byte(8'($urandom_range('h90, 'hBF)));
        put_byte(8'($urandom_range('h80, 'hBF)));
        put_byte(8'($urandom_range('h80, 'hBF)));
      end
      default: begin
        put_utf8_char(random_char_value(0));
      end
    endcase
  endfunction

  task automatic send_random_string(input logic [2:0] m);
    int  n;
    bit  wide;
    n = $urandom_range(1, 6);
    wide = (m == MODE_U16BE) || (m == MODE_U16LE) || (m == MODE_U16BOM);
    if (m == MODE_U16BOM && $urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1) == 1) begin
        put_byte(8'hFE);
        put_byte(8'hFF);
      end else begin
        put_byte(8'hFF);
        put_byte(8'hFE);
      end
    end
    for (int k = 0; k < n; k++) begin
      if (m == MODE_UTF8) begin
        put_utf8_element();
      end else if (wide) begin
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end
    if (wide && $urandom_range(0, 3) == 0) put_byte(8'($urandom_range(0, 255)));
    send_text();
  endtask

  function automatic logic [2:0] phase_mode(input int p);
    case (p % 12)
      0:       return MODE_UTF8;
      1:       return MODE_SPARE7;
      2:       return MODE_U16BOM;
      3:       return MODE_SPARE6;
      4:       return MODE_UTF8;
      5:       return MODE_U16LE;
      6:       return MODE_ASCII;
      7:       return MODE_UTF8;
      8:       return MODE_U16BE;
      9:       return MODE_LATIN1;
      10:      return MODE_UTF8;
      default: return MODE_U16BOM;
    endcase
  endfunction

  initial begin
    int first_random;
    int p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset mode is Latin-1.
    text = '{8'h00, 8'hFF};
    send_text();
    drain();

    // UTF-8: a character, a surrogate pair, a bad lead, a broken sequence, an overlong
    // form, a surrogate value, a value past the limit and a cut-off end.
    set_mode(MODE_UTF8);
    text = '{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hC3, 8'h41, 8'hC0, 8'h80,
             8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hE2, 8'h82};
    send_text();
    drain();

    set_mode(MODE_ASCII);
    text = '{8'h7F, 8'h80};
    send_text();
    drain();

    // Little-endian mark then a stray odd byte; a bare big-endian mark ends with no unit.
    set_mode(MODE_U16BOM);
    text = '{8'hFF, 8'hFE, 8'h41, 8'h00, 8'h7A};
    send_text();
    text = '{8'hFE, 8'hFF};
    send_text();
    drain();

    first_random = sent;
    p = 0;
    while (sent - first_random < RANDOM_BYTES) begin
      set_mode(phase_mode(p));
      for (int s = 0; s < 3; s++) begin
        calm = (sent - first_random >= RANDOM_BYTES - CALM_BYTES);
        send_random_string(phase_mode(p));
      end
      drain();
      p++;
    end

    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
